// ===== sv/ilie_pkg.sv =====
package ilie_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int WORD_BITS   = 32;

  // Width of the live count, which must hold MAX_ENTRIES itself.
  localparam int IDX_W = $clog2(MAX_ENTRIES + 1);
  // Width of a cell position, 0 .. MAX_ENTRIES-1.
  localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // Fixed field widths of the stream payload.
  localparam int FUNC_W   = 3;
  localparam int IN_IDX_W = 7;
  localparam int VALUE_W  = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;

  // Common width for comparisons between field values and the live count.
  localparam int CNT_W = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;

  // Read-out tree shape.
  localparam int GROUP    = 8;
  localparam int N_GROUPS = (MAX_ENTRIES + GROUP - 1) / GROUP;

  localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RESIZE = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic              en;
    logic [FUNC_W-1:0] func;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  req;
    word_t             word;
  } cell_cmd_t;

  // The stored word keeps the low WORD_BITS bits of the value.
  function automatic word_t value_to_word(input logic [VALUE_W-1:0] v);
    word_t w;
    w = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (i < VALUE_W) begin
        w[i] = v[i];
      end
    end
    return w;
  endfunction

  // The read field shows the low VALUE_W bits of a stored word.
  function automatic logic [VALUE_W-1:0] word_to_read(input word_t w);
    logic [VALUE_W-1:0] r;
    r = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (i < WORD_BITS) begin
        r[i] = w[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/ilie_cell.sv =====
module ilie_cell
  import ilie_pkg::*;
(
  input  logic             clk,
  input  logic [POS_W-1:0] pos,
  input  cell_cmd_t        cmd,
  input  word_t            left_word,
  input  word_t            right_word,
  output word_t            word,
  output word_t            rd_word
);

  word_t            word_r;
  word_t            word_nxt;
  word_t            rd_r;
  word_t            rd_nxt;
  logic [CNT_W-1:0] p;

  always_comb begin
    p        = CNT_W'(pos);
    word_nxt = word_r;
    rd_nxt   = '0;
    if (cmd.en) begin
      case (cmd.func)
        FN_READ: begin
          if (p == cmd.idx) begin
            rd_nxt = word_r;
          end
        end
        FN_WRITE: begin
          if (p == cmd.idx) begin
            word_nxt = cmd.word;
          end
        end
        FN_APPEND: begin
          if (p == cmd.len) begin
            word_nxt = cmd.word;
          end
        end
        FN_INSERT: begin
          // Cells above the insert point take the word of the cell below.
          if (p == cmd.idx) begin
            word_nxt = cmd.word;
          end else if (p > cmd.idx && p <= cmd.len) begin
            word_nxt = left_word;
          end
        end
        FN_REMOVE: begin
          if (p >= cmd.idx && (p + 1'b1) < cmd.len) begin
            word_nxt = right_word;
          end
        end
        FN_RESIZE: begin
          if (p >= cmd.len && p < cmd.req) begin
            word_nxt = '0;
          end
        end
        default: begin
          word_nxt = word_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rd_r   <= rd_nxt;
  end

  assign word    = word_r;
  assign rd_word = rd_r;

endmodule

// ===== sv/ilie_or_tree.sv =====
module ilie_or_tree
  import ilie_pkg::*;
(
  input  logic  clk,
  input  logic  load_grp,
  input  logic  load_sum,
  input  word_t leaf [MAX_ENTRIES],
  output word_t result
);

  // At most one leaf is nonzero, so an OR of all leaves selects it.
  word_t grp_r [N_GROUPS];
  word_t grp_nxt [N_GROUPS];
  word_t sum_r;
  word_t sum_nxt;

  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < MAX_ENTRIES) begin
          grp_nxt[g] = grp_nxt[g] | leaf[g * GROUP + k];
        end
      end
    end
    sum_nxt = '0;
    for (int g = 0; g < N_GROUPS; g++) begin
      sum_nxt = sum_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (load_grp) begin
      for (int g = 0; g < N_GROUPS; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (load_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign result = sum_r;

endmodule

// ===== sv/indexed_list_insert_erase_core.sv =====
// Ordered list of up to MAX_ENTRIES words with a live length.
// The input stream carries one operation per transfer: read, write, append,
// insert, remove or resize. Every input transfer yields exactly one output
// transfer with the read word, the length after the operation and a status
// (ok, index out of range, capacity exceeded).
// The words sit in a row of cells; insert and remove move all affected
// cells by one place in the cycle the input transfer happens.
// A read word comes back through the cell's read register and a two-level
// registered OR tree (group, then sum). The block holds one operation at
// a time: in_tready is low from the input transfer until the result
// transfer, so a new item is taken only after the last result is taken.
// When the receiver stalls, the result holds on out_tdata and no
// new item is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; word contents are undefined until written.
module indexed_list_insert_erase_core
  import ilie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: func[2:0], index[9:3], value[41:10], new_length[48:42]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: read_value[31:0], length[38:32], status[40:39]
  output logic [47:0] out_tdata
);

  logic [FUNC_W-1:0]   f;
  logic [CNT_W-1:0]    ix;
  logic [CNT_W-1:0]    rq;
  logic [CNT_W-1:0]    lv;
  logic [VALUE_W-1:0]  v;
  logic [STATUS_W-1:0] st;
  logic                accept;

  logic [IDX_W-1:0]    live_r;
  logic [IDX_W-1:0]    live_nxt;
  logic                busy_r;
  logic                p1_r;
  logic                p2_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [LEN_W-1:0]    length_r;

  cell_cmd_t cmd;
  word_t     cell_word [MAX_ENTRIES];
  word_t     cell_rd [MAX_ENTRIES];
  word_t     tree_out;

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_ENTRIES);

  assign in_tready = rst_n && !busy_r;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    f        = in_tdata[2:0];
    ix       = CNT_W'(in_tdata[9:3]);
    v        = in_tdata[41:10];
    rq       = CNT_W'(in_tdata[48:42]);
    lv       = CNT_W'(live_r);
    st       = ST_OK;
    live_nxt = live_r;
    unique case (f) inside
      FN_READ, FN_WRITE: begin
        if (ix >= lv) begin
          st = ST_RANGE;
        end
      end
      FN_APPEND: begin
        if (lv >= MAXC) begin
          st = ST_FULL;
        end else begin
          live_nxt = live_r + 1'b1;
        end
      end
      FN_INSERT: begin
        if (ix > lv) begin
          st = ST_RANGE;
        end else if (lv >= MAXC) begin
          st = ST_FULL;
        end else begin
          live_nxt = live_r + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (ix >= lv) begin
          st = ST_RANGE;
        end else begin
          live_nxt = live_r - 1'b1;
        end
      end
      FN_RESIZE: begin
        if (rq > MAXC) begin
          st = ST_FULL;
        end else begin
          live_nxt = IDX_W'(rq);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase

    cmd.en   = accept && (st == ST_OK);
    cmd.func = f;
    cmd.idx  = ix;
    cmd.len  = lv;
    cmd.req  = rq;
    cmd.word = value_to_word(v);
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    ilie_cell u_cell (
      .clk        (clk),
      .pos        (POS_W'(i)),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .rd_word    (cell_rd[i])
    );
  end

  ilie_or_tree u_tree (
    .clk      (clk),
    .load_grp (p1_r),
    .load_sum (p2_r),
    .leaf     (cell_rd),
    .result   (tree_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      busy_r      <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_r <= accept;
      p2_r <= p1_r;
      if (accept) begin
        live_r <= live_nxt;
        busy_r <= 1'b1;
      end
      if (p2_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
        busy_r      <= 1'b0;
      end
    end
    if (accept) begin
      status_r <= st;
      length_r <= LEN_W'(live_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, status_r, length_r, word_to_read(tree_out)};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

import ilie_pkg::*;

typedef struct {
  logic [VALUE_W-1:0]  rd;
  logic [LEN_W-1:0]    len;
  logic [STATUS_W-1:0] st;
} list_answer_t;

// Keeps a shadow copy of the list and the answers still owed by the block.
class list_tracker;
  word_t        cells [MAX_ENTRIES];
  int           count = 0;
  list_answer_t answers [$];
  int unsigned  errors = 0;

  function void apply_op(input logic [FUNC_W-1:0] fn, input logic [IN_IDX_W-1:0] idx,
                         input logic [VALUE_W-1:0] val, input logic [LEN_W-1:0] nlen);
    list_answer_t a;
    int i;
    a.rd = '0;
    a.st = ST_OK;
    case (fn)
      FN_READ: begin
        if (idx >= count) a.st = ST_RANGE;
        else a.rd = cells[idx];
      end
      FN_WRITE: begin
        if (idx >= count) a.st = ST_RANGE;
        else cells[idx] = val;
      end
      FN_APPEND: begin
        if (count >= MAX_ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          cells[count] = val;
          count++;
        end
      end
      FN_INSERT: begin
        // The range check wins over the capacity check.
        if (idx > count) begin
          a.st = ST_RANGE;
        end else if (count >= MAX_ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          for (i = count; i > idx; i--) cells[i] = cells[i-1];
          cells[idx] = val;
          count++;
        end
      end
      FN_REMOVE: begin
        if (idx >= count) begin
          a.st = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < count; i++) cells[i] = cells[i+1];
          count--;
        end
      end
      FN_RESIZE: begin
        if (nlen > MAX_ENTRIES) begin
          a.st = ST_FULL;
        end else begin
          for (i = count; i < nlen; i++) cells[i] = '0;
          count = int'(nlen);
        end
      end
      default: begin
      end
    endcase
    a.len = LEN_W'(count);
    answers.insert(answers.size(), a);
  endfunction

  function void check_result(input logic [47:0] data);
    list_answer_t a;
    list_answer_t got;
    got.rd  = data[31:0];
    got.len = data[38:32];
    got.st  = data[40:39];
    if (answers.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: read %h length %0d status %0d",
                 got.rd, got.len, got.st);
      return;
    end
    a = answers.pop_front();
    if (got.rd !== a.rd || got.len !== a.len || got.st !== a.st) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: expected read %h length %0d status %0d, ",
                  "got read %h length %0d status %0d"},
                 a.rd, a.len, a.st, got.rd, got.len, got.st);
    end
  endfunction
endclass

module testbench;

  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [55:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [47:0] out_tdata;

  list_tracker tracker = new;
  bit          no_idle  = 1'b0;
  bit          hold_req = 1'b0;

  indexed_list_insert_erase_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [IN_IDX_W-1:0] idx,
                         input logic [VALUE_W-1:0] val, input logic [LEN_W-1:0] nlen);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, nlen, val, idx, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.apply_op(fn, idx, val, nlen);
  endtask

  // Mostly well-formed operations aimed at live entries, with some noise.
  task automatic send_random_op();
    logic [FUNC_W-1:0]   fn;
    logic [IN_IDX_W-1:0] idx;
    logic [VALUE_W-1:0]  val;
    logic [LEN_W-1:0]    nlen;
    int pick;
    int cnt;
    cnt  = tracker.count;
    pick = $urandom_range(0, 99);
    idx  = IN_IDX_W'($urandom_range(0, 127));
    nlen = LEN_W'($urandom_range(0, 127));
    val  = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: val = '0;
        1: val = '1;
        2: val = 32'h8000_0000;
        default: val = 32'h7FFF_FFFF;
      endcase
    end
    if (pick < 20) begin
      fn = FN_READ;
      idx = (cnt > 0) ? IN_IDX_W'($urandom_range(0, cnt - 1)) : '0;
    end else if (pick < 35) begin
      fn = FN_WRITE;
      idx = (cnt > 0) ? IN_IDX_W'($urandom_range(0, cnt - 1)) : '0;
    end else if (pick < 47) begin
      fn = FN_APPEND;
    end else if (pick < 62) begin
      fn = FN_INSERT;
      idx = IN_IDX_W'($urandom_range(0, cnt));
    end else if (pick < 80) begin
      fn = FN_REMOVE;
      idx = (cnt > 0) ? IN_IDX_W'($urandom_range(0, cnt - 1)) : '0;
    end else if (pick < 90) begin
      fn = FN_RESIZE;
      nlen = LEN_W'($urandom_range(0, MAX_ENTRIES));
    end else begin
      fn = FUNC_W'($urandom_range(0, 7));
    end
    send_op(fn, idx, val, nlen);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int wait_cycles;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        wait_cycles = no_idle ? 0 : $urandom_range(0, 4);
        if (wait_cycles > 0) begin
          out_tready <= 1'b0;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_result(out_tdata);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: everything that needs an entry is out of range.
    send_op(FN_READ,   7'd0,   32'h0000_0000, 7'd0);
    send_op(FN_REMOVE, 7'd0,   32'h0000_0000, 7'd0);
    send_op(FN_INSERT, 7'd1,   32'h1111_1111, 7'd0);
    send_op(FN_INSERT, 7'd0,   32'h7FFF_FFFF, 7'd0);
    send_op(FN_APPEND, 7'd127, 32'h8000_0000, 7'd127);
    send_op(FN_INSERT, 7'd1,   32'hFFFF_FFFF, 7'd0);
    send_op(FN_INSERT, 7'd3,   32'h0000_0000, 7'd0);
    send_op(FN_WRITE,  7'd2,   32'h1234_5678, 7'd0);
    send_op(FN_WRITE,  7'd4,   32'hDEAD_BEEF, 7'd0);
    send_op(FN_READ,   7'd1,   32'h0000_0000, 7'd0);
    send_op(FN_READ,   7'd3,   32'h0000_0000, 7'd0);
    send_op(FN_REMOVE, 7'd0,   32'h0000_0000, 7'd0);
    send_op(FN_REMOVE, 7'd2,   32'h0000_0000, 7'd0);
    send_op(FN_READ,   7'd1,   32'h0000_0000, 7'd0);
    // Growing exposes zero-filled entries; shrinking only lowers the length.
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd10);
    send_op(FN_READ,   7'd9,   32'h0000_0000, 7'd0);
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd3);
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd65);
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd127);
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd64);
    send_op(FN_APPEND, 7'd0,   32'h5555_5555, 7'd0);
    send_op(FN_INSERT, 7'd64,  32'hAAAA_AAAA, 7'd0);
    send_op(FN_INSERT, 7'd65,  32'hAAAA_AAAA, 7'd0);
    send_op(FN_READ,   7'd63,  32'h0000_0000, 7'd0);
    send_op(FN_READ,   7'd127, 32'h0000_0000, 7'd0);
    send_op(FN_SPARE_LO, 7'd5, 32'hFFFF_FFFF, 7'd127);
    send_op(FN_SPARE_HI, 7'd0, 32'h0000_0000, 7'd0);
    send_op(FN_RESIZE, 7'd0,   32'h0000_0000, 7'd0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 200) begin
        in_tvalid <= 1'b0;
        while (tracker.answers.size() != 0) @(posedge clk);
      end
      no_idle = (n >= 260 && n < 320);
      send_random_op();
    end
    in_tvalid <= 1'b0;

    while (tracker.answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== indexed_list_insert_erase_core.f =====
sv/ilie_pkg.sv
sv/ilie_cell.sv
sv/ilie_or_tree.sv
sv/indexed_list_insert_erase_core.sv
tb/sv/testbench.sv
